### src/dsam_pkg.sv
// ----------------------------------------------------------------------------
// dsam_pkg
// Shared types, codes and sizes for the domain scope allowlist matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package dsam_pkg;

  localparam int TABLE_ENTRIES = 256;
  localparam int NAME_CHARS    = 128;
  localparam int MAX_KEEP      = NAME_CHARS - 1;
  localparam int IDX_W         = $clog2(NAME_CHARS);
  localparam int ENT_W         = $clog2(TABLE_ENTRIES);
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
  localparam int TXT_AW        = ENT_W + IDX_W;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

  localparam logic [1:0] FUNC_LOAD  = 2'd0;
  localparam logic [1:0] FUNC_CHECK = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  localparam logic [1:0] RK_LOAD  = 2'd0;
  localparam logic [1:0] RK_CHECK = 2'd1;
  localparam logic [1:0] RK_CLEAR = 2'd2;

  localparam logic [1:0] V_INSCOPE  = 2'd0;
  localparam logic [1:0] V_OUTSCOPE = 2'd1;
  localparam logic [1:0] V_NOAPPR   = 2'd2;
  localparam logic [1:0] V_NOENT    = 2'd3;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_CHECK,
    OP_CLEAR
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_META,
    ST_DEC,
    ST_CRD,
    ST_CCMP,
    ST_EMIT
  } eng_state_e;

  typedef struct packed {
    op_e         op;
    logic [7:0]  ch;
    logic        last;
    logic        wild;
    logic        appr;
    logic [31:0] fnum;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } qhead_t;

endpackage

`default_nettype wire

### src/dsam_if.sv
// ----------------------------------------------------------------------------
// dsam_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface dsam_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [7:0]  char_byte;
  logic        last_char;
  logic        wildcard_entry;
  logic        approved;
  logic [31:0] finding_number;

  modport source (output valid, func, char_byte, last_char, wildcard_entry, approved,
                  finding_number, input ready);
  modport sink (input valid, func, char_byte, last_char, wildcard_entry, approved,
                finding_number, output ready);
endinterface

interface dsam_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [31:0] finding_echo;
  logic [1:0]  verdict;
  logic        load_accepted;
  logic [8:0]  entries_held;
  logic [31:0] checks_count;
  logic [31:0] inscope_count;
  logic [31:0] outscope_count;
  logic [31:0] unapproved_count;

  modport source (output valid, result_kind, finding_echo, verdict, load_accepted,
                  entries_held, checks_count, inscope_count, outscope_count,
                  unapproved_count, input ready);
  modport sink (input valid, result_kind, finding_echo, verdict, load_accepted,
                entries_held, checks_count, inscope_count, outscope_count,
                unapproved_count, output ready);
endinterface

`default_nettype wire

### src/domain_scope_allowlist_match.sv
// ----------------------------------------------------------------------------
// domain_scope_allowlist_match
// Allowlist of exact and wildcard domains; gives a scope verdict per target.
// ----------------------------------------------------------------------------
// Channels: in_i takes one character transaction per handshake (load, check
// or clear); out_o gives one result on the last character of a load or check
// and on every clear. Both are valid/ready.
// A four-deep queue decouples acceptance from the engine, which, when idle,
// takes one queued item per cycle for loads, clears and non-last check
// characters. A last approved check character with a non-empty table starts
// a table walk: per entry a meta read and decode, then per character a read
// and compare, ending at the first match or after the last entry; the
// verdict is then registered. The walk is bound by the single read port of
// the entry text memory. Reset empties the table and zeroes the counters;
// memory contents are left as they are and are never used before written.
// When out_o stalls, the result register holds; the engine waits only for
// items that give a result, and the queue keeps accepting until it fills.
// ----------------------------------------------------------------------------
`default_nettype none

module domain_scope_allowlist_match import dsam_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  dsam_in_if.sink     in_i,
  dsam_out_if.source  out_o
);

  qhead_t head;
  logic   pop;

  dsam_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .head_o (head),
    .pop_i  (pop)
  );

  dsam_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .out_o  (out_o)
  );

endmodule

`default_nettype wire

### src/dsam_front.sv
// ----------------------------------------------------------------------------
// dsam_front
// Accepts input transactions, classifies them and queues them for the engine.
// ----------------------------------------------------------------------------
`default_nettype none

module dsam_front import dsam_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  dsam_in_if.sink     in_i,
  output qhead_t      head_o,
  input  wire logic   pop_i
);

  item_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QPTR_W:0]   cnt_q;
  logic              push, pop, drop;
  item_t             cls;

  assign in_i.ready = (cnt_q != (QPTR_W+1)'(QUEUE_DEPTH));

  always_comb begin
    cls.ch   = in_i.char_byte;
    cls.last = in_i.last_char;
    cls.wild = in_i.wildcard_entry;
    cls.appr = in_i.approved;
    cls.fnum = in_i.finding_number;
    drop     = 1'b0;
    case (in_i.func)
      FUNC_LOAD:  cls.op = OP_LOAD;
      FUNC_CHECK: cls.op = OP_CHECK;
      FUNC_CLEAR: cls.op = OP_CLEAR;
      default: begin
        cls.op = OP_CLEAR;
        drop   = 1'b1;  // unused selector, no effect
      end
    endcase
  end

  assign push = in_i.valid && in_i.ready && !drop;
  assign pop  = pop_i && (cnt_q != '0);

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= cls;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop)  rd_q <= rd_q + 1'b1;
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  assign head_o.valid = (cnt_q != '0);
  assign head_o.item  = mem_q[rd_q];

endmodule

`default_nettype wire

### src/dsam_engine.sv
// ----------------------------------------------------------------------------
// dsam_engine
// Executes queued items: table and target buffering, table walk, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dsam_engine import dsam_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire qhead_t head_i,
  output logic        pop_o,
  dsam_out_if.source  out_o
);

  eng_state_e         state_q, state_d;
  logic [CNT_W-1:0]   et_q, et_d;
  logic [IDX_W-1:0]   lp_q, lp_d, tl_q, tl_d;
  logic [ENT_W-1:0]   ent_q, ent_d;
  logic [IDX_W-1:0]   k_q, k_d, base_q, base_d, el_q, el_d;
  logic [1:0]         vd_q, vd_d;
  logic [31:0]        fnum_q, fnum_d;
  logic [31:0]        chk_q, chk_d, ins_q, ins_d, outs_q, outs_d, unap_q, unap_d;

  // memories
  logic [7:0]         text_mem [TABLE_ENTRIES*NAME_CHARS];
  logic [IDX_W:0]     meta_mem [TABLE_ENTRIES];
  logic [7:0]         tgt_mem  [NAME_CHARS];
  logic [7:0]         text_rd_q, tgt_rd_q;
  logic [IDX_W:0]     meta_rd_q;
  logic               text_we, meta_we, tgt_we;
  logic [TXT_AW-1:0]  text_wa;
  logic [IDX_W:0]     meta_wd;

  // result register
  logic               out_vq, out_load, out_free;
  logic [1:0]         o_kind, o_vd;
  logic [31:0]        o_echo;
  logic               o_acc;

  item_t              it;
  logic               full, ld_store, ck_store, ok, nxt_last;
  logic [IDX_W-1:0]   el, el_m1;
  logic               wild;

  assign it       = head_i.item;
  assign full     = (et_q >= CNT_W'(TABLE_ENTRIES));
  assign ld_store = !full && (it.ch != 8'd0) && (lp_q < IDX_W'(MAX_KEEP));
  assign ck_store = (it.ch != 8'd0) && (tl_q < IDX_W'(MAX_KEEP));
  assign out_free = !out_vq || out_o.ready;
  assign text_wa  = {et_q[ENT_W-1:0], lp_q};
  assign el       = meta_rd_q[IDX_W-1:0];
  assign wild     = meta_rd_q[IDX_W];
  assign ok       = wild ? (tl_q >= el) : (tl_q == el);
  assign el_m1    = el_q - 1'b1;
  assign nxt_last = (({1'b0, ent_q} + 1'b1) == et_q);

  always_comb begin
    state_d = state_q;
    et_d = et_q; lp_d = lp_q; tl_d = tl_q;
    ent_d = ent_q; k_d = k_q; base_d = base_q; el_d = el_q;
    vd_d = vd_q; fnum_d = fnum_q;
    chk_d = chk_q; ins_d = ins_q; outs_d = outs_q; unap_d = unap_q;
    pop_o = 1'b0; text_we = 1'b0; meta_we = 1'b0; tgt_we = 1'b0;
    meta_wd = '0;
    out_load = 1'b0; o_kind = RK_LOAD; o_vd = V_INSCOPE; o_echo = '0; o_acc = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (head_i.valid) begin
          case (it.op)
            OP_LOAD: begin
              if (!it.last || out_free) begin
                pop_o   = 1'b1;
                text_we = ld_store;
                lp_d    = ld_store ? lp_q + 1'b1 : lp_q;
                if (it.last) begin
                  if (!full) begin
                    meta_we = 1'b1;
                    meta_wd = {it.wild, lp_d};
                    et_d    = et_q + 1'b1;
                  end
                  lp_d     = '0;
                  out_load = 1'b1;
                  o_kind   = RK_LOAD;
                  o_acc    = !full;
                end
              end
            end
            OP_CHECK: begin
              pop_o  = 1'b1;
              tgt_we = ck_store;
              tl_d   = ck_store ? tl_q + 1'b1 : tl_q;
              if (it.last) begin
                fnum_d = it.fnum;
                ent_d  = '0;
                if (et_q == '0) begin
                  vd_d    = V_NOENT;
                  state_d = ST_EMIT;
                end else if (!it.appr) begin
                  vd_d    = V_NOAPPR;
                  state_d = ST_EMIT;
                end else begin
                  state_d = ST_META;
                end
              end
            end
            OP_CLEAR: begin
              if (out_free) begin
                pop_o = 1'b1;
                et_d = '0; lp_d = '0; tl_d = '0;
                chk_d = '0; ins_d = '0; outs_d = '0; unap_d = '0;
                out_load = 1'b1;
                o_kind   = RK_CLEAR;
              end
            end
            default: ;
          endcase
        end
      end
      ST_META: state_d = ST_DEC;  // meta read in flight
      ST_DEC: begin
        el_d   = el;
        k_d    = '0;
        base_d = wild ? (tl_q - el) : '0;
        if (ok && el == '0) begin
          vd_d    = V_INSCOPE;
          state_d = ST_EMIT;
        end else if (ok) begin
          state_d = ST_CRD;
        end else if (nxt_last) begin
          vd_d    = V_OUTSCOPE;
          state_d = ST_EMIT;
        end else begin
          ent_d   = ent_q + 1'b1;
          state_d = ST_META;
        end
      end
      ST_CRD: state_d = ST_CCMP;  // char reads in flight
      ST_CCMP: begin
        if (text_rd_q != tgt_rd_q) begin
          if (nxt_last) begin
            vd_d    = V_OUTSCOPE;
            state_d = ST_EMIT;
          end else begin
            ent_d   = ent_q + 1'b1;
            state_d = ST_META;
          end
        end else if (k_q == el_m1) begin
          vd_d    = V_INSCOPE;
          state_d = ST_EMIT;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = ST_CRD;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          chk_d = chk_q + 1'b1;
          case (vd_q)
            V_INSCOPE:  ins_d  = ins_q + 1'b1;
            V_OUTSCOPE: outs_d = outs_q + 1'b1;
            V_NOAPPR:   unap_d = unap_q + 1'b1;
            default: ;
          endcase
          tl_d     = '0;
          out_load = 1'b1;
          o_kind   = RK_CHECK;
          o_vd     = vd_q;
          o_echo   = fnum_q;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (text_we) text_mem[text_wa] <= it.ch;
    if (meta_we) meta_mem[et_q[ENT_W-1:0]] <= meta_wd;
    if (tgt_we)  tgt_mem[tl_q] <= it.ch;
    text_rd_q <= text_mem[{ent_q, k_q}];
    tgt_rd_q  <= tgt_mem[base_q + k_q];
    meta_rd_q <= meta_mem[ent_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      et_q <= '0; lp_q <= '0; tl_q <= '0;
      ent_q <= '0; k_q <= '0; base_q <= '0; el_q <= '0;
      vd_q <= V_INSCOPE; fnum_q <= '0;
      chk_q <= '0; ins_q <= '0; outs_q <= '0; unap_q <= '0;
      out_vq <= 1'b0;
    end else begin
      state_q <= state_d;
      et_q <= et_d; lp_q <= lp_d; tl_q <= tl_d;
      ent_q <= ent_d; k_q <= k_d; base_q <= base_d; el_q <= el_d;
      vd_q <= vd_d; fnum_q <= fnum_d;
      chk_q <= chk_d; ins_q <= ins_d; outs_q <= outs_d; unap_q <= unap_d;
      if (out_load)         out_vq <= 1'b1;
      else if (out_o.ready) out_vq <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_o.result_kind      <= o_kind;
      out_o.finding_echo     <= o_echo;
      out_o.verdict          <= o_vd;
      out_o.load_accepted    <= o_acc;
      out_o.entries_held     <= 9'(et_d);
      out_o.checks_count     <= chk_d;
      out_o.inscope_count    <= ins_d;
      out_o.outscope_count   <= outs_d;
      out_o.unapproved_count <= unap_d;
    end
  end

  assign out_o.valid = out_vq;

endmodule

`default_nettype wire

### test/tb_domain_scope_allowlist_match.sv
// ----------------------------------------------------------------------------
// tb_domain_scope_allowlist_match
// Self-checking bench for the allowlist matcher: a queue-fed driver streams
// load, check and clear characters with random gaps, a monitor with random
// back-pressure compares every result against an in-bench scope predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_domain_scope_allowlist_match;
  import dsam_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [1:0]  func;
    logic [7:0]  ch;
    logic        last;
    logic        wild;
    logic        appr;
    logic [31:0] fnum;
  } char_txn_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] echo;
    logic [1:0]  verdict;
    logic        accepted;
    logic [8:0]  held;
    logic [31:0] checks;
    logic [31:0] inscope;
    logic [31:0] outscope;
    logic [31:0] unapproved;
  } scope_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  dsam_in_if  in_ch ();
  dsam_out_if out_ch ();

  domain_scope_allowlist_match DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [7:0]  tbl_text [TABLE_ENTRIES][NAME_CHARS];
  int          tbl_len  [TABLE_ENTRIES];
  logic        tbl_wild [TABLE_ENTRIES];
  int          tbl_count;
  int          load_pos;
  logic [7:0]  tgt_text [NAME_CHARS];
  int          tgt_len;
  logic [31:0] n_checks, n_inscope, n_outscope, n_unapproved;

  char_txn_t     pending_chars [$];
  scope_result_t results_due [$];
  int            error_count = 0;
  int            gen_items = 0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    error_count++;
  endtask

  function automatic bit entry_hit(input int e);
    int el;
    int off;
    el = tbl_len[e];
    if (tbl_wild[e]) begin
      if (tgt_len < el) return 1'b0;
      off = tgt_len - el;
    end else begin
      if (tgt_len != el) return 1'b0;
      off = 0;
    end
    for (int k = 0; k < el; k++)
      if (tgt_text[off + k] != tbl_text[e][k]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic scope_predict(input char_txn_t t);
    scope_result_t r;
    bit full;
    bit hit;
    bit emit;
    r = '0;
    emit = 1'b0;
    case (t.func)
      FUNC_LOAD: begin
        full = tbl_count >= TABLE_ENTRIES;
        if (!full && t.ch != 8'd0 && load_pos < MAX_KEEP) begin
          tbl_text[tbl_count][load_pos] = t.ch;
          load_pos++;
        end
        if (t.last) begin
          if (!full) begin
            tbl_len[tbl_count] = load_pos;
            tbl_wild[tbl_count] = t.wild;
            tbl_count++;
          end
          load_pos = 0;
          r.kind = RK_LOAD;
          r.accepted = !full;
          emit = 1'b1;
        end
      end
      FUNC_CHECK: begin
        if (t.ch != 8'd0 && tgt_len < MAX_KEEP) begin
          tgt_text[tgt_len] = t.ch;
          tgt_len++;
        end
        if (t.last) begin
          n_checks++;
          if (tbl_count == 0) begin
            r.verdict = V_NOENT;
          end else if (!t.appr) begin
            r.verdict = V_NOAPPR;
            n_unapproved++;
          end else begin
            hit = 1'b0;
            for (int e = 0; e < tbl_count && !hit; e++) hit = entry_hit(e);
            if (hit) begin
              r.verdict = V_INSCOPE;
              n_inscope++;
            end else begin
              r.verdict = V_OUTSCOPE;
              n_outscope++;
            end
          end
          tgt_len = 0;
          r.kind = RK_CHECK;
          r.echo = t.fnum;
          emit = 1'b1;
        end
      end
      FUNC_CLEAR: begin
        tbl_count = 0;
        load_pos = 0;
        tgt_len = 0;
        n_checks = '0;
        n_inscope = '0;
        n_outscope = '0;
        n_unapproved = '0;
        r.kind = RK_CLEAR;
        emit = 1'b1;
      end
      default: ;
    endcase
    if (emit) begin
      r.held = tbl_count[8:0];
      r.checks = n_checks;
      r.inscope = n_inscope;
      r.outscope = n_outscope;
      r.unapproved = n_unapproved;
      results_due.push_back(r);
    end
  endtask

  // ---------------- driver ----------------
  char_txn_t drv_txn;
  int        gap_left;
  bit        drv_idle_on;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.func <= FUNC_LOAD;
      in_ch.char_byte <= '0;
      in_ch.last_char <= 1'b0;
      in_ch.wildcard_entry <= 1'b0;
      in_ch.approved <= 1'b0;
      in_ch.finding_number <= '0;
      gap_left <= 0;
      drv_idle_on <= 1'b1;
    end else begin
      if (in_ch.valid && in_ch.ready) scope_predict(drv_txn);
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_ch.valid <= 1'b0;
        end else if (pending_chars.size() != 0) begin
          drv_txn = pending_chars.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.func <= drv_txn.func;
          in_ch.char_byte <= drv_txn.ch;
          in_ch.last_char <= drv_txn.last;
          in_ch.wildcard_entry <= drv_txn.wild;
          in_ch.approved <= drv_txn.appr;
          in_ch.finding_number <= drv_txn.fnum;
          if ($urandom_range(0, 63) == 0) drv_idle_on <= !drv_idle_on;
          gap_left <= drv_idle_on ? $urandom_range(0, 15) : 0;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------- monitor ----------------
  int stall_left;
  bit mon_stall_on;

  always @(posedge clk_i or negedge rst_ni) begin
    scope_result_t want;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      stall_left <= 0;
      mon_stall_on <= 1'b1;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (results_due.size() == 0) begin
          report("unexpected result kind", 32'(out_ch.result_kind), 32'hx);
        end else begin
          want = results_due.pop_front();
          if (out_ch.result_kind !== want.kind)
            report("result_kind", 32'(out_ch.result_kind), 32'(want.kind));
          if (out_ch.finding_echo !== want.echo)
            report("finding_echo", out_ch.finding_echo, want.echo);
          if (out_ch.verdict !== want.verdict)
            report("verdict", 32'(out_ch.verdict), 32'(want.verdict));
          if (out_ch.load_accepted !== want.accepted)
            report("load_accepted", 32'(out_ch.load_accepted), 32'(want.accepted));
          if (out_ch.entries_held !== want.held)
            report("entries_held", 32'(out_ch.entries_held), 32'(want.held));
          if (out_ch.checks_count !== want.checks)
            report("checks_count", out_ch.checks_count, want.checks);
          if (out_ch.inscope_count !== want.inscope)
            report("inscope_count", out_ch.inscope_count, want.inscope);
          if (out_ch.outscope_count !== want.outscope)
            report("outscope_count", out_ch.outscope_count, want.outscope);
          if (out_ch.unapproved_count !== want.unapproved)
            report("unapproved_count", out_ch.unapproved_count, want.unapproved);
        end
        if ($urandom_range(0, 31) == 0) mon_stall_on <= !mon_stall_on;
        stall_left <= mon_stall_on ? $urandom_range(0, 15) : 0;
        out_ch.ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------- stimulus ----------------
  task automatic add(input logic [1:0] f, input logic [7:0] c, input logic l,
                     input logic w, input logic a, input logic [31:0] n);
    char_txn_t t;
    t.func = f;
    t.ch = c;
    t.last = l;
    t.wild = w;
    t.appr = a;
    t.fnum = n;
    pending_chars.push_back(t);
    gen_items++;
  endtask

  // Streams a string; an empty one is a lone zero character marked last.
  task automatic add_str(input logic [1:0] f, input logic [7:0] s[], input int n,
                         input logic w, input logic a);
    if (n == 0) begin
      add(f, 8'd0, 1'b1, w, a, $urandom);
    end else begin
      for (int k = 0; k < n; k++)
        add(f, s[k], k == n - 1, (k == n - 1) ? w : 1'($urandom),
            (k == n - 1) ? a : 1'($urandom), $urandom);
    end
  endtask

  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return 8'h61 + 8'($urandom_range(0, 3));
    if (r < 95) return 8'($urandom_range(1, 255));
    return 8'd0;
  endfunction

  logic [7:0] gen_txt [64][16];
  int         gen_len [64];
  int         gen_count;

  initial begin
    logic [7:0] s [];
    int n, p, pre, sel;
    s = new[140];
    tbl_count = 0;
    load_pos = 0;
    tgt_len = 0;
    n_checks = '0;
    n_inscope = '0;
    n_outscope = '0;
    n_unapproved = '0;

    // directed: empty table, exact/wildcard, approval, zero char, interleave
    add(FUNC_CLEAR, 8'hff, 1'b1, 1'b1, 1'b1, 32'hffff_ffff);
    s[0] = "a"; s[1] = "b";
    add_str(FUNC_CHECK, s, 2, 1'b0, 1'b1);
    add_str(FUNC_LOAD, s, 2, 1'b0, 1'b0);
    s[0] = "."; s[1] = "c";
    add_str(FUNC_LOAD, s, 2, 1'b1, 1'b0);
    s[0] = "x"; s[1] = "."; s[2] = "c";
    add_str(FUNC_CHECK, s, 3, 1'b0, 1'b0);
    add_str(FUNC_CHECK, s, 3, 1'b0, 1'b1);
    s[0] = "a"; s[1] = "b";
    add_str(FUNC_CHECK, s, 2, 1'b0, 1'b1);
    s[0] = "a"; s[1] = "b"; s[2] = "d";
    add_str(FUNC_CHECK, s, 3, 1'b0, 1'b1);
    add(FUNC_CHECK, 8'h80, 1'b0, 1'b0, 1'b0, 32'h0);
    add(FUNC_LOAD, 8'hff, 1'b0, 1'b0, 1'b0, 32'h0);
    add(FUNC_CHECK, 8'h00, 1'b1, 1'b1, 1'b1, 32'h0);
    add(FUNC_LOAD, 8'h01, 1'b1, 1'b0, 1'b1, 32'hffff_ffff);
    add(2'd3, 8'h55, 1'b1, 1'b1, 1'b1, 32'h5555_aaaa);
    add(FUNC_CHECK, 8'h00, 1'b1, 1'b0, 1'b1, 32'h1234_5678);
    add(FUNC_LOAD, 8'h00, 1'b1, 1'b1, 1'b0, 32'h0);
    add(FUNC_CHECK, 8'h7f, 1'b1, 1'b0, 1'b1, 32'hdead_beef);

    // overlong strings are cut to the kept length
    add(FUNC_CLEAR, 8'h00, 1'b0, 1'b0, 1'b0, 32'h0);
    for (int k = 0; k < 140; k++) s[k] = "x";
    add_str(FUNC_LOAD, s, 130, 1'b0, 1'b0);
    add_str(FUNC_CHECK, s, 127, 1'b0, 1'b1);
    add_str(FUNC_CHECK, s, 135, 1'b0, 1'b1);
    add_str(FUNC_CHECK, s, 126, 1'b0, 1'b1);

    // full table and rejected loads
    add(FUNC_CLEAR, 8'h00, 1'b0, 1'b0, 1'b0, 32'h0);
    for (int k = 0; k < TABLE_ENTRIES; k++)
      add(FUNC_LOAD, 8'($urandom_range(1, 255)), 1'b1, 1'($urandom), 1'b0, $urandom);
    s[0] = "q"; s[1] = "r"; s[2] = "s";
    add_str(FUNC_LOAD, s, 3, 1'b1, 1'b0);
    add_str(FUNC_LOAD, s, 3, 1'b0, 1'b0);
    for (int k = 0; k < 4; k++) begin
      s[0] = 8'($urandom_range(1, 255)); s[1] = 8'($urandom_range(1, 255));
      add_str(FUNC_CHECK, s, 1 + (k % 2), 1'b0, 1'b1);
    end
    add(FUNC_CLEAR, 8'h00, 1'b0, 1'b0, 1'b0, 32'h0);

    // random: loads of short strings and checks, mostly built from them
    gen_count = 0;
    while (gen_items < 1550) begin
      sel = $urandom_range(0, 99);
      if (sel < 3) begin
        add(FUNC_CLEAR, 8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom), $urandom);
        gen_count = 0;
      end else if (sel < 6) begin
        add(2'd3, 8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom), $urandom);
      end else if (sel < 36 && gen_count < 40) begin
        n = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 6);
        for (int k = 0; k < n; k++) s[k] = pick_char();
        add_str(FUNC_LOAD, s, n, 1'($urandom), 1'($urandom));
        gen_len[gen_count] = n;
        for (int k = 0; k < n; k++) gen_txt[gen_count][k] = s[k];
        gen_count++;
      end else begin
        n = 0;
        if (gen_count != 0 && $urandom_range(0, 3) != 0) begin
          p = $urandom_range(0, gen_count - 1);
          pre = $urandom_range(0, 3);
          for (int k = 0; k < pre; k++) s[n++] = pick_char();
          for (int k = 0; k < gen_len[p]; k++) s[n++] = gen_txt[p][k];
          if (n != 0 && $urandom_range(0, 5) == 0) s[$urandom_range(0, n - 1)] = pick_char();
        end else begin
          n = $urandom_range(0, 8);
          for (int k = 0; k < n; k++) s[k] = pick_char();
        end
        add_str(FUNC_CHECK, s, n, 1'($urandom), $urandom_range(0, 99) < 85);
      end
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    do @(posedge clk_i);
    while (pending_chars.size() != 0 || in_ch.valid || results_due.size() != 0);
    repeat (2000) @(posedge clk_i);
    if (results_due.size() != 0) report("results still due", 32'(results_due.size()), 32'd0);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire
